// File: rtl/battery_level_gauge_top_defines.svh
// Assertion macros used by the checker file.
`ifndef BATTERY_LEVEL_GAUGE_TOP_DEFINES_SVH
`define BATTERY_LEVEL_GAUGE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BLG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("blg assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("blg assertion failed");

`endif

// File: rtl/blg_pkg.sv
`timescale 1ns / 1ps

package blg_pkg;

  localparam int unsigned DEF_ADC_BITS  = 10;
  localparam int unsigned DEF_TIME_BITS = 32;

  localparam int unsigned VOLT_W  = 21;
  localparam int unsigned LVL_W   = 7;
  localparam int unsigned MV_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W   = $clog2(VOLT_W);

  localparam logic [VOLT_W-1:0] REF_RST   = VOLT_W'(1125300);
  localparam logic [MV_W-1:0]   EMPTY_RST = MV_W'(2900);
  localparam logic [MV_W-1:0]   HOLD_RST  = MV_W'(1000);

  localparam int unsigned LVL_MAX    = 100;
  // 10 mV per percent: any difference at or above this saturates
  localparam int unsigned CLAMP_DIFF = 1010;
  // x / 10 == (x * 205) >> 11 for x < 1029
  localparam int unsigned RECIP      = 205;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF   = 2'd0,
    CFG_EMPTY = 2'd1,
    CFG_HOLD  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_LEVEL,
    S_FILT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;      // input transfer: latch fields
    logic decide;    // hold check, divider setup
    logic div_step;  // one quotient bit
    logic level;     // voltage to percent
    logic filt;      // IIR update
    logic out_load;  // fill output register
  } cmd_t;

  typedef struct packed {
    logic hold;
    logic div_done;
  } sts_t;

  function automatic logic [LVL_W-1:0] div10(input logic [9:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'(RECIP);
    return p[17:11];
  endfunction

endpackage

// File: rtl/blg_ctrl.sv
`timescale 1ns / 1ps

module blg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  blg_pkg::sts_t sts_i,
  output blg_pkg::cmd_t cmd_o
);
  import blg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE: state_d = sts_i.hold ? S_DONE : S_DIV;
      S_DIV:    if (sts_i.div_done) state_d = S_LEVEL;
      S_LEVEL:  state_d = S_FILT;
      S_FILT:   state_d = S_DONE;
      S_DONE:   if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    cmd_o.load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_DECIDE: cmd_o.decide   = 1'b1;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_LEVEL:  cmd_o.level    = 1'b1;
      S_FILT:   cmd_o.filt     = 1'b1;
      S_DONE:   cmd_o.out_load = !out_valid_q || !out_stall_i;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/blg_dp.sv
`timescale 1ns / 1ps

module blg_dp #(
  parameter int unsigned ADC_BITS  = blg_pkg::DEF_ADC_BITS,
  parameter int unsigned TIME_BITS = blg_pkg::DEF_TIME_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  blg_pkg::cmd_t                       cmd_i,
  output blg_pkg::sts_t                       sts_o,
  input  logic                                cfg_we_i,
  input  logic [blg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [blg_pkg::VOLT_W-1:0]          cfg_data_i,
  input  logic [TIME_BITS-1:0]                now_ms_i,
  input  logic [ADC_BITS-1:0]                 adc_raw_i,
  output logic [blg_pkg::LVL_W-1:0]           level_pct_o,
  output logic [blg_pkg::VOLT_W-1:0]          voltage_mv_o,
  output logic                                sampled_o
);
  import blg_pkg::*;

  // configuration
  logic [VOLT_W-1:0] ref_q;
  logic [MV_W-1:0]   empty_q;
  logic [MV_W-1:0]   hold_q;

  // kept state
  logic [LVL_W-1:0]     level_q, level_d;
  logic [TIME_BITS-1:0] last_time_q;
  logic [VOLT_W-1:0]    last_volt_q;

  // working registers
  logic [TIME_BITS-1:0] now_q;
  logic [ADC_BITS-1:0]  raw_q;
  logic [ADC_BITS-1:0]  rem_q, rem_d;
  logic [VOLT_W-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [LVL_W-1:0]     meas_q, meas_d;
  logic                 sampled_q;

  logic [LVL_W-1:0]     lvl_out_q;
  logic [VOLT_W-1:0]    volt_out_q;
  logic                 smp_out_q;

  logic [TIME_BITS-1:0] elapsed;
  logic [ADC_BITS:0]    trial;
  logic                 ge;
  logic [VOLT_W-1:0]    diff;
  logic [LVL_W-1:0]     prev;
  logic [9:0]           sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= REF_RST;
      empty_q <= EMPTY_RST;
      hold_q  <= HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REF:   ref_q   <= cfg_data_i;
        CFG_EMPTY: empty_q <= cfg_data_i[MV_W-1:0];
        CFG_HOLD:  hold_q  <= cfg_data_i[MV_W-1:0];
        default:   ;
      endcase
    end
  end

  assign elapsed    = now_q - last_time_q;
  assign sts_o.hold = (level_q != '0) && (elapsed < TIME_BITS'(hold_q));

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_q, quo_q[VOLT_W-1]};
  assign ge    = trial >= {1'b0, raw_q};
  always_comb begin
    rem_d = ge ? ADC_BITS'(trial - {1'b0, raw_q}) : trial[ADC_BITS-1:0];
    quo_d = {quo_q[VOLT_W-2:0], ge};
  end
  assign sts_o.div_done = cnt_q == CNT_W'(VOLT_W - 1);

  assign diff = quo_q - VOLT_W'(empty_q);
  always_comb begin
    if (quo_q <= VOLT_W'(empty_q)) begin
      meas_d = '0;
    end else if (diff >= VOLT_W'(CLAMP_DIFF)) begin
      meas_d = LVL_W'(LVL_MAX);
    end else begin
      meas_d = div10(diff[9:0]);
    end
  end

  // zero kept level: filter starts from the new measurement
  assign prev    = (level_q == '0) ? meas_q : level_q;
  assign sum     = 10'({prev, 3'b000}) + 10'(prev) + 10'(meas_q);
  assign level_d = div10(sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      last_time_q <= '0;
      last_volt_q <= '0;
    end else begin
      if (cmd_i.decide && !sts_o.hold) last_time_q <= now_q;
      if (cmd_i.level) last_volt_q <= quo_q;
      if (cmd_i.filt)  level_q     <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= now_ms_i;
      raw_q <= (adc_raw_i == '0) ? ADC_BITS'(1) : adc_raw_i;
    end
    if (cmd_i.decide) begin
      sampled_q <= !sts_o.hold;
      rem_q     <= '0;
      quo_q     <= ref_q;
      cnt_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.level) meas_q <= meas_d;
    if (cmd_i.out_load) begin
      lvl_out_q  <= level_q;
      volt_out_q <= last_volt_q;
      smp_out_q  <= sampled_q;
    end
  end

  assign level_pct_o  = lvl_out_q;
  assign voltage_mv_o = volt_out_q;
  assign sampled_o    = smp_out_q;

endmodule

// File: rtl/battery_level_gauge_top.sv
`timescale 1ns / 1ps
// channel | valid       | stall       | payload
// --------+-------------+-------------+-----------------------------------
// input   | in_valid_i  | in_stall_o  | now_ms_i, adc_raw_i
// output  | out_valid_o | out_stall_i | level_pct_o, voltage_mv_o, sampled_o
//
// One item at a time. A held (cached) item goes from decide straight to done; a
// sampled item also passes the divide, level and filter states; the restoring
// divider produces the 21-bit voltage one quotient bit per cycle.
// Reset restores the register defaults and clears level, sample time and voltage.
// A finished result sits in the output register; a new input is taken while it
// waits, and a second result behind it waits, input stalled, until the first leaves.

module battery_level_gauge_top #(
  parameter int unsigned ADC_BITS  = blg_pkg::DEF_ADC_BITS,
  parameter int unsigned TIME_BITS = blg_pkg::DEF_TIME_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [blg_pkg::VOLT_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [TIME_BITS-1:0]          now_ms_i,
  input  logic [ADC_BITS-1:0]           adc_raw_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [blg_pkg::LVL_W-1:0]     level_pct_o,
  output logic [blg_pkg::VOLT_W-1:0]    voltage_mv_o,
  output logic                          sampled_o
);
  import blg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  blg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  blg_dp #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .now_ms_i     (now_ms_i),
    .adc_raw_i    (adc_raw_i),
    .level_pct_o  (level_pct_o),
    .voltage_mv_o (voltage_mv_o),
    .sampled_o    (sampled_o)
  );

endmodule

// File: rtl/blg_chk.sv
`timescale 1ns / 1ps
`include "battery_level_gauge_top_defines.svh"

module blg_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [blg_pkg::LVL_W-1:0]  level_pct_o,
  input logic [blg_pkg::VOLT_W-1:0] voltage_mv_o,
  input logic                       sampled_o
);
  import blg_pkg::*;

  // a stalled result stays and keeps its payload
  `BLG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(level_pct_o) && $stable(voltage_mv_o) && $stable(sampled_o))
  // the block is busy right after an input transfer
  `BLG_ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o)
  // level never exceeds full scale
  `BLG_ASSERT_NOW(a_level_range, out_valid_o, level_pct_o <= LVL_W'(LVL_MAX))
  // a cached result only comes from a nonzero kept level
  `BLG_ASSERT_NOW(a_cache_nonzero, out_valid_o && !sampled_o, level_pct_o != '0)

endmodule

bind battery_level_gauge_top blg_chk u_blg_chk (.*);

// File: tb/battery_level_gauge_top_tb.sv
`timescale 1ns / 1ps

module battery_level_gauge_top_tb;
  import blg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;  // unmapped index
  localparam int unsigned WDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYC = 30;
  localparam int unsigned MAX_REPORT = 10;

  typedef struct packed {
    logic [LVL_W-1:0]  lvl;
    logic [VOLT_W-1:0] mv;
    logic              smp;
  } gauge_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [VOLT_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [31:0]          now_ms;
  logic [9:0]           adc_raw;
  logic                 out_valid;
  logic                 out_stall;
  logic [LVL_W-1:0]     level_pct;
  logic [VOLT_W-1:0]    voltage_mv;
  logic                 sampled;

  // predictor copy of registers and state
  logic [VOLT_W-1:0] ref_k;
  logic [MV_W-1:0]   empty_k;
  logic [MV_W-1:0]   hold_k;
  logic [LVL_W-1:0]  kept_level;
  logic [31:0]       last_time;
  logic [VOLT_W-1:0] last_mv;

  gauge_res_t  reading_q[$];
  gauge_res_t  want;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] t_now;

  battery_level_gauge_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .now_ms_i     (now_ms),
    .adc_raw_i    (adc_raw),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .level_pct_o  (level_pct),
    .voltage_mv_o (voltage_mv),
    .sampled_o    (sampled)
  );

  always #5 clk = ~clk;

  function automatic gauge_res_t predict_gauge(input logic [31:0] now,
                                               input logic [9:0] raw);
    logic [31:0]  elapsed;
    logic [VOLT_W-1:0] mv;
    int unsigned  meas;
    gauge_res_t   r;
    elapsed = now - last_time;
    r.smp = 1'b0;
    if (kept_level == '0 || elapsed >= {16'b0, hold_k}) begin
      r.smp = 1'b1;
      last_time = now;
      mv = ref_k / ((raw == '0) ? VOLT_W'(1) : VOLT_W'(raw));
      last_mv = mv;
      if (mv <= VOLT_W'(empty_k)) begin
        meas = 0;
      end else begin
        meas = (32'(mv) - 32'(empty_k)) / 10;
        if (meas > LVL_MAX) meas = LVL_MAX;
      end
      if (kept_level == '0) kept_level = LVL_W'(meas);
      kept_level = LVL_W'((9 * 32'(kept_level) + meas) / 10);
    end
    r.lvl = kept_level;
    r.mv  = last_mv;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VOLT_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_REF:   ref_k   = val;
      CFG_EMPTY: empty_k = val[MV_W-1:0];
      CFG_HOLD:  hold_k  = val[MV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_reading(input logic [31:0] now, input logic [9:0] raw);
    @(negedge clk);
    in_valid <= 1'b1;
    now_ms   <= now;
    adc_raw  <= raw;
    do @(posedge clk); while (in_stall);
    reading_q.push_back(predict_gauge(now, raw));
  endtask

  task automatic pause_input(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // all results back, then let the block settle before touching registers
  task automatic drain_results();
    while (reading_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reading_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("unexpected result: lvl=%0d mv=%0d smp=%0b",
                   level_pct, voltage_mv, sampled);
      end else begin
        want = reading_q.pop_front();
        if (want.lvl !== level_pct || want.mv !== voltage_mv || want.smp !== sampled) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("mismatch: exp lvl=%0d mv=%0d smp=%0b, got lvl=%0d mv=%0d smp=%0b",
                     want.lvl, want.mv, want.smp, level_pct, voltage_mv, sampled);
        end
      end
    end
  end

  // receiver stall pattern: free runs, light/heavy random stalls, solid stalls
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = (stall_mode == 3) ? $urandom_range(1, 20) : $urandom_range(10, 80);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= 1'b1;
    endcase
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_sample_and_hold();
    send_reading(32'd0, 10'd300);          // first load of the filter
    send_reading(32'd500, 10'd0);          // held
    send_reading(32'd999, 10'd1023);       // held, one short of hold
    send_reading(32'd1000, 10'd0);         // zero reading treated as one
    send_reading(32'd1500, 10'd1023);
    send_reading(32'd2000, 10'd1023);      // below empty
    send_reading(32'hFFFF_FFFF, 10'd512);
    send_reading(32'h0000_0100, 10'd512);  // time wrap, still held
    send_reading(32'h0000_03E7, 10'd512);  // wrapped elapsed equals hold
    pause_input(1);
    drain_results();
  endtask

  task automatic test_reg_extremes();
    write_reg(CFG_REF, '0);
    write_reg(CFG_HOLD, '0);
    send_reading(32'd3000, 10'd1);
    send_reading(32'd3001, 10'd1023);
    pause_input(1);
    drain_results();
    // upper data bits must be dropped for the 16-bit registers
    write_reg(CFG_REF, '1);
    write_reg(CFG_EMPTY, '1);
    write_reg(CFG_HOLD, '1);
    write_reg(CFG_NONE, '0);
    send_reading(32'd5000, 10'd0);
    send_reading(32'd3001 + 32'd65535, 10'd0);
    send_reading(32'd3001 + 32'd65535 + 32'd65534, 10'd7);
    pause_input(1);
    drain_results();
    write_reg(CFG_EMPTY, '0);
    write_reg(CFG_REF, VOLT_W'(1));
    write_reg(CFG_HOLD, '0);
    send_reading(32'd7, 10'd1);
    send_reading(32'd7, 10'd0);
    pause_input(1);
    drain_results();
  endtask

  function automatic logic [9:0] pick_adc();
    int unsigned center;
    int          v;
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      2, 3, 4: return 10'($urandom_range(0, 1023));
      default: begin
        // aim at readings that land between empty and full
        center = ref_k / (32'(empty_k) + 500);
        if (center == 0 || center > 1023) return 10'($urandom_range(0, 1023));
        v = int'(center) + int'($urandom_range(0, 60)) - 30;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return 10'(v);
      end
    endcase
  endfunction

  function automatic logic [31:0] next_time();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return t_now - $urandom_range(0, 200);
      2: return t_now + hold_k - $urandom_range(0, 1);
      default: return t_now + $urandom_range(0, 2 * 32'(hold_k) + 2);
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      while (burst != 0 && sent < n_items) begin
        t_now = next_time();
        send_reading(t_now, pick_adc());
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
    end
    pause_input(1);
    drain_results();
  endtask

  task automatic test_random_readings();
    write_reg(CFG_REF, VOLT_W'(1125300));
    write_reg(CFG_EMPTY, VOLT_W'(2900));
    write_reg(CFG_HOLD, VOLT_W'(1000));
    t_now = 32'hFFFF_F000;
    run_random_phase(150);
    write_reg(CFG_REF, VOLT_W'($urandom_range(500000, 2097151)));
    write_reg(CFG_EMPTY, VOLT_W'($urandom_range(0, 4000)));
    write_reg(CFG_HOLD, VOLT_W'($urandom_range(0, 300)));
    run_random_phase(150);
    // high empty level: the filter decays to zero and reloads
    write_reg(CFG_REF, '1);
    write_reg(CFG_EMPTY, '1);
    write_reg(CFG_HOLD, '0);
    write_reg(CFG_NONE, VOLT_W'($urandom));
    run_random_phase(150);
    write_reg(CFG_REF, VOLT_W'($urandom));
    write_reg(CFG_EMPTY, VOLT_W'($urandom));
    write_reg(CFG_HOLD, VOLT_W'($urandom_range(0, 2000)) | (VOLT_W'($urandom) & 21'h1F0000));
    run_random_phase(150);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_REF;
    cfg_data  = '0;
    in_valid  = 1'b0;
    now_ms    = '0;
    adc_raw   = '0;
    ref_k      = REF_RST;
    empty_k    = EMPTY_RST;
    hold_k     = HOLD_RST;
    kept_level = '0;
    last_time  = '0;
    last_mv    = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_sample_and_hold();
    test_reg_extremes();
    test_random_readings();

    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/blg_pkg.sv
rtl/blg_ctrl.sv
rtl/blg_dp.sv
rtl/battery_level_gauge_top.sv
rtl/blg_chk.sv
tb/battery_level_gauge_top_tb.sv
